/* design/pscl_pkg.sv */
// ----------------------------------------------------------------------------
// pscl_pkg
// Shared types and constants of the per-stop compacting client list.
// ----------------------------------------------------------------------------
`default_nettype none

package pscl_pkg;

    localparam int NUM_STOPS = 8;
    localparam int SLOTS     = 16;

    localparam int ID_W      = 31;
    localparam int DEST_W    = 4;
    localparam int STOPF_W   = 3;
    localparam int SLOTF_W   = 4;
    localparam int STATUS_W  = 2;

    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int STOP_W    = (NUM_STOPS > 1) ? $clog2(NUM_STOPS) : 1;
    localparam int BASE_W    = 1 + STOP_W;
    localparam int ADDR_W    = BASE_W + SLOT_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_MISSING  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_CLEAR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               func;
        logic               side;
        logic [STOPF_W-1:0] stop;
        logic [ID_W-1:0]    client_id;
        logic [DEST_W-1:0]  destination;
    } t_item;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ID_W-1:0]   wr_id;
        logic [DEST_W-1:0] wr_dest;
    } t_ram_req;

    typedef struct packed {
        t_status            status;
        logic [SLOTF_W-1:0] slot;
    } t_result;

endpackage

`default_nettype wire

/* design/per_stop_compacting_client_list.sv */
// ----------------------------------------------------------------------------
// per_stop_compacting_client_list
// Two banks of per-stop client lists with insert into the first free slot
// and remove with compaction of the later slots.
// ----------------------------------------------------------------------------
// An insert scans up to the first free slot and writes it; a remove scans to the
// identifier, shifts every later slot down and clears the last; a miss scans all
// slots. The scan reads one slot a cycle through the single-read-port slot store.
// Throughput: one item at a time; the next item is accepted once the result
// has moved into the output register. A rejected stop or zero identifier goes
// straight to its result. Reset is synchronous and frees every slot at once.
`default_nettype none

module per_stop_compacting_client_list
    import pscl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_func,
    input  wire logic               i_side,
    input  wire logic [STOPF_W-1:0] i_stop,
    input  wire logic [ID_W-1:0]    i_client_id,
    input  wire logic [DEST_W-1:0]  i_destination,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [STATUS_W-1:0]     o_status,
    output logic [SLOTF_W-1:0]      o_slot
);

    t_item       item;
    t_ram_req    req;
    t_result     res;
    logic        ready;
    logic        res_vld;
    logic        res_take;
    logic [ID_W-1:0]   rd_id;
    logic [DEST_W-1:0] rd_dest;

    logic        r_out_vld;
    t_result     r_out;

    assign item.func        = i_func;
    assign item.side        = i_side;
    assign item.stop        = i_stop;
    assign item.client_id   = i_client_id;
    assign item.destination = i_destination;

    pscl_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_vld   (i_valid),
        .i_item     (item),
        .o_ready    (ready),
        .o_req      (req),
        .i_rd_id    (rd_id),
        .i_rd_dest  (rd_dest),
        .o_res_vld  (res_vld),
        .o_res      (res),
        .i_res_take (res_take)
    );

    pscl_slot_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_rd_id   (rd_id),
        .o_rd_dest (rd_dest)
    );

    // The output register takes a result when it is empty or being emptied.
    assign res_take = res_vld && (!r_out_vld || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_take) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_stall  = !ready;
    assign o_valid  = r_out_vld;
    assign o_status = r_out.status;
    assign o_slot   = r_out.slot;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block took an item without turning busy");

    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL || o_status == ST_MISSING)) |-> (o_slot == '0))
        else $error("failed result carries a nonzero slot");

    a_take_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_take |=> (o_valid && o_status == $past(res.status) && o_slot == $past(res.slot)))
        else $error("result did not reach the output register");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ready |-> !req.wr_en)
        else $error("slot store written while idle");

endmodule

`default_nettype wire

/* design/pscl_slot_ram.sv */
// ----------------------------------------------------------------------------
// pscl_slot_ram
// Slot store for both banks: one write and one registered read per cycle,
// with a valid bit per entry so that reset frees every slot at once.
// ----------------------------------------------------------------------------
`default_nettype none

module pscl_slot_ram
    import pscl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ram_req          i_req,
    output logic [ID_W-1:0]        o_rd_id,
    output logic [DEST_W-1:0]      o_rd_dest
);

    logic [ID_W-1:0]      r_mem_id   [MEM_DEPTH];
    logic [DEST_W-1:0]    r_mem_dest [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_valid;
    logic [ID_W-1:0]      r_rd_id;
    logic [DEST_W-1:0]    r_rd_dest;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem_id[i_req.wr_addr]   <= i_req.wr_id;
            r_mem_dest[i_req.wr_addr] <= i_req.wr_dest;
        end
        if (i_req.rd_en) begin
            r_rd_id   <= r_mem_id[i_req.rd_addr];
            r_rd_dest <= r_mem_dest[i_req.rd_addr];
            r_rd_vld  <= r_valid[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    // An entry never written since reset reads as a free slot.
    assign o_rd_id   = r_rd_vld ? r_rd_id   : '0;
    assign o_rd_dest = r_rd_vld ? r_rd_dest : '0;

endmodule

`default_nettype wire

/* design/pscl_seq.sv */
// ----------------------------------------------------------------------------
// pscl_seq
// Sequencer that walks the slots of one list through the shared compare
// unit, then writes the new client or shifts the later slots down.
// ----------------------------------------------------------------------------
`default_nettype none

module pscl_seq
    import pscl_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_vld,
    input  wire t_item        i_item,
    output logic              o_ready,
    output t_ram_req          o_req,
    input  wire logic [ID_W-1:0]   i_rd_id,
    input  wire logic [DEST_W-1:0] i_rd_dest,
    output logic              o_res_vld,
    output t_result           o_res,
    input  wire logic         i_res_take
);

    localparam logic [SLOT_W:0]   CNT_END  = (SLOT_W+1)'(SLOTS);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

    t_state              r_state, n_state;
    logic                r_func, n_func;
    logic [BASE_W-1:0]   r_base, n_base;
    logic [ID_W-1:0]     r_id, n_id;
    logic [DEST_W-1:0]   r_dest, n_dest;
    logic [SLOT_W:0]     r_rd_idx, n_rd_idx;
    logic                r_cmp_vld, n_cmp_vld;
    logic [SLOT_W-1:0]   r_cmp_idx, n_cmp_idx;
    t_result             r_res, n_res;

    logic [31:0]         stop_ext;
    logic                bad_item;
    logic                hit;
    logic                issue;

    assign stop_ext = 32'(i_item.stop);
    assign bad_item = (stop_ext >= 32'(NUM_STOPS)) || (i_item.client_id == '0);

    // Shared compare unit: a free slot for insert, the identifier for remove.
    assign hit   = r_func ? (i_rd_id == r_id) : (i_rd_id == '0);
    assign issue = (r_rd_idx < CNT_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_base    <= n_base;
        r_id      <= n_id;
        r_dest    <= n_dest;
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_res     <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_base    = r_base;
        n_id      = r_id;
        n_dest    = r_dest;
        n_rd_idx  = r_rd_idx;
        n_cmp_vld = r_cmp_vld;
        n_cmp_idx = r_cmp_idx;
        n_res     = r_res;
        o_req     = '0;
        o_ready   = 1'b0;
        o_res_vld = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_in_vld) begin
                    n_func    = i_item.func;
                    n_base    = {i_item.side, stop_ext[STOP_W-1:0]};
                    n_id      = i_item.client_id;
                    n_dest    = i_item.destination;
                    n_rd_idx  = '0;
                    n_cmp_vld = 1'b0;
                    if (bad_item) begin
                        n_res.status = i_item.func ? ST_MISSING : ST_FULL;
                        n_res.slot   = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // Reads run one slot ahead of the compare.
                if (issue) begin
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = {r_base, r_rd_idx[SLOT_W-1:0]};
                    n_rd_idx      = r_rd_idx + 1'b1;
                    n_cmp_idx     = r_rd_idx[SLOT_W-1:0];
                end
                n_cmp_vld = issue;
                if (r_cmp_vld) begin
                    if (hit) begin
                        n_res.slot = SLOTF_W'(r_cmp_idx);
                        if (r_func) begin
                            n_res.status = ST_REMOVED;
                            // The read of the next slot is already out.
                            n_state = (r_cmp_idx == LAST_IDX) ? S_CLEAR : S_SHIFT;
                        end else begin
                            n_res.status  = ST_INSERTED;
                            o_req.wr_en   = 1'b1;
                            o_req.wr_addr = {r_base, r_cmp_idx};
                            o_req.wr_id   = r_id;
                            o_req.wr_dest = r_dest;
                            n_state       = S_DONE;
                        end
                    end else if (r_cmp_idx == LAST_IDX) begin
                        n_res.status = r_func ? ST_MISSING : ST_FULL;
                        n_res.slot   = '0;
                        n_state      = S_DONE;
                    end
                end
            end

            S_SHIFT: begin
                // Data read from slot r_cmp_idx moves down one place.
                o_req.wr_en   = 1'b1;
                o_req.wr_addr = {r_base, SLOT_W'(r_cmp_idx - 1'b1)};
                o_req.wr_id   = i_rd_id;
                o_req.wr_dest = i_rd_dest;
                if (r_cmp_idx == LAST_IDX) begin
                    n_state = S_CLEAR;
                end else begin
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = {r_base, r_rd_idx[SLOT_W-1:0]};
                    n_rd_idx      = r_rd_idx + 1'b1;
                    n_cmp_idx     = r_rd_idx[SLOT_W-1:0];
                end
            end

            S_CLEAR: begin
                o_req.wr_en   = 1'b1;
                o_req.wr_addr = {r_base, LAST_IDX};
                o_req.wr_id   = '0;
                o_req.wr_dest = '0;
                n_state       = S_DONE;
            end

            S_DONE: begin
                o_res_vld = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

`default_nettype wire
